FILE: hdl/gsg_pkg.sv
// Package: widths, codes, config struct, CORDIC types and arctangent table for the grid step controller
`default_nettype none
package gsg_pkg;

    localparam int POS_W      = 24;
    localparam int DIFF_W     = POS_W + 1;
    localparam int SUM_W      = POS_W + 2;
    localparam int HEAD_W     = 15;
    localparam int ANG_W      = 16;
    localparam int ERR_W      = 17;
    localparam int LIN_W      = 18;
    localparam int RATE_W     = 15;
    localparam int DIR_W      = 3;

    localparam int STEP_W     = 18;
    localparam int TOL_W      = 16;
    localparam int HTOL_W     = 13;
    localparam int TURN_W     = 14;
    localparam int FWD_W      = 18;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;

    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SQ_W       = PROD_W - 1;
    localparam int D2_W       = SQ_W + 1;
    localparam int TOL2_W     = 2 * TOL_W;

    localparam int CORDIC_ITERATIONS = 14;
    localparam int TAB_LEN           = 20;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < TAB_LEN) ? CORDIC_ITERATIONS
                                                                       : TAB_LEN;
    localparam int ITER_W            = $clog2(TAB_LEN);
    localparam int FRAC_SHIFT        = 16;
    localparam int CW                = DIFF_W + FRAC_SHIFT + 3;

    localparam logic signed [ERR_W-1:0] ANG_PI      = 17'sd12868;
    localparam logic signed [ERR_W-1:0] ANG_TWO_PI  = 17'sd25736;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 16'sd6434;

    localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

    localparam logic CMD_POSE = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_SIZE    = 3'd0,
        REG_ARRIVE_TOL   = 3'd1,
        REG_HEADING_TOL  = 3'd2,
        REG_TURN_RATE    = 3'd3,
        REG_FORWARD_SPD  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [STEP_W-1:0] step_size;
        logic [TOL_W-1:0]  arrive_tolerance;
        logic [HTOL_W-1:0] heading_tolerance;
        logic [TURN_W-1:0] turn_rate;
        logic [FWD_W-1:0]  forward_speed;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        step_size:         18'd65536,
        arrive_tolerance:  16'd3277,
        heading_tolerance: 13'd205,
        turn_rate:         14'd6144,
        forward_speed:     18'd65536
    };

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } t_cordic_req;

    typedef struct packed {
        logic                    done;
        logic signed [ANG_W-1:0] angle;
    } t_cordic_rsp;

    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            5'd0:    val = 16'sd3217;
            5'd1:    val = 16'sd1899;
            5'd2:    val = 16'sd1003;
            5'd3:    val = 16'sd509;
            5'd4:    val = 16'sd256;
            5'd5:    val = 16'sd128;
            5'd6:    val = 16'sd64;
            5'd7:    val = 16'sd32;
            5'd8:    val = 16'sd16;
            5'd9:    val = 16'sd8;
            5'd10:   val = 16'sd4;
            5'd11:   val = 16'sd2;
            5'd12:   val = 16'sd1;
            default: val = 16'sd0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/gsg_in_if.sv
// Interface: command/pose input channel
`default_nettype none
interface gsg_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic [gsg_pkg::DIR_W-1:0]            direction;
    logic signed [gsg_pkg::POS_W-1:0]     pose_x;
    logic signed [gsg_pkg::POS_W-1:0]     pose_y;
    logic signed [gsg_pkg::HEAD_W-1:0]    pose_heading;

    modport source (output valid, command, direction, pose_x, pose_y, pose_heading,
                    input ready);
    modport sink   (input valid, command, direction, pose_x, pose_y, pose_heading,
                    output ready);
endinterface
`default_nettype wire

FILE: hdl/gsg_out_if.sv
// Interface: drive command output channel
`default_nettype none
interface gsg_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [gsg_pkg::LIN_W-1:0]            linear_speed;
    logic signed [gsg_pkg::RATE_W-1:0]    angular_rate;
    logic                                 arrived;

    modport source (output valid, linear_speed, angular_rate, arrived, input ready);
    modport sink   (input valid, linear_speed, angular_rate, arrived, output ready);
endinterface
`default_nettype wire

FILE: hdl/gsg_cfg.sv
// Configuration register bank written through the plain write port
`default_nettype none
module gsg_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [gsg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [gsg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output gsg_pkg::t_cfg                           o_cfg
);

    gsg_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= gsg_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (gsg_pkg::t_reg_idx'(i_cfg_idx))
                gsg_pkg::REG_STEP_SIZE: begin
                    r_cfg.step_size <= i_cfg_data[gsg_pkg::STEP_W-1:0];
                end
                gsg_pkg::REG_ARRIVE_TOL: begin
                    r_cfg.arrive_tolerance <= i_cfg_data[gsg_pkg::TOL_W-1:0];
                end
                gsg_pkg::REG_HEADING_TOL: begin
                    r_cfg.heading_tolerance <= i_cfg_data[gsg_pkg::HTOL_W-1:0];
                end
                gsg_pkg::REG_TURN_RATE: begin
                    r_cfg.turn_rate <= i_cfg_data[gsg_pkg::TURN_W-1:0];
                end
                gsg_pkg::REG_FORWARD_SPD: begin
                    r_cfg.forward_speed <= i_cfg_data[gsg_pkg::FWD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

FILE: hdl/gsg_cordic.sv
// Iterative CORDIC vectoring unit: bearing of (dx, dy), one rotation per cycle
`default_nettype none
module gsg_cordic (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire gsg_pkg::t_cordic_req i_req,
    output gsg_pkg::t_cordic_rsp    o_rsp
);

    localparam int CW = gsg_pkg::CW;

    logic                                 r_busy;
    logic                                 r_done;
    logic                                 r_zero;
    logic [gsg_pkg::ITER_W-1:0]           r_iter;
    logic signed [CW-1:0]                 r_x;
    logic signed [CW-1:0]                 r_y;
    logic signed [gsg_pkg::ANG_W-1:0]     r_z;

    logic signed [CW-1:0]                 x_in;
    logic signed [CW-1:0]                 y_in;
    logic signed [CW-1:0]                 x0;
    logic signed [CW-1:0]                 y0;
    logic signed [gsg_pkg::ANG_W-1:0]     z0;
    logic signed [CW-1:0]                 sh_x;
    logic signed [CW-1:0]                 sh_y;
    logic signed [gsg_pkg::ANG_W-1:0]     atan_v;
    logic                                 last_iter;

    assign x_in = CW'(i_req.dx) <<< gsg_pkg::FRAC_SHIFT;
    assign y_in = CW'(i_req.dy) <<< gsg_pkg::FRAC_SHIFT;

    // quadrant pre-rotation for the left half plane
    always_comb begin
        x0 = x_in;
        y0 = y_in;
        z0 = '0;
        if (x_in < 0) begin
            if (y_in >= 0) begin
                x0 = y_in;
                y0 = -x_in;
                z0 = gsg_pkg::ANG_HALF_PI;
            end else begin
                x0 = -y_in;
                y0 = x_in;
                z0 = -gsg_pkg::ANG_HALF_PI;
            end
        end
    end

    assign sh_x      = r_x >>> r_iter;
    assign sh_y      = r_y >>> r_iter;
    assign atan_v    = gsg_pkg::atan_entry(r_iter);
    assign last_iter = (r_iter == gsg_pkg::ITER_W'(gsg_pkg::CORDIC_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && r_busy && last_iter;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
                r_x    <= x0;
                r_y    <= y0;
                r_z    <= z0;
                r_zero <= (i_req.dx == '0) && (i_req.dy == '0);
            end else if (r_busy) begin
                if (!r_y[CW-1]) begin
                    r_x <= r_x + sh_y;
                    r_y <= r_y - sh_x;
                    r_z <= r_z + atan_v;
                end else begin
                    r_x <= r_x - sh_y;
                    r_y <= r_y + sh_x;
                    r_z <= r_z - atan_v;
                end
                r_iter <= r_iter + 1'b1;
                if (last_iter) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.angle = r_zero ? '0 : r_z;

endmodule
`default_nettype wire

FILE: hdl/grid_step_goto_controller_unit.sv
// Top level: grid step go-to-goal controller with sequencer, shared multiplier and CORDIC
//
// Channels: i_cmd takes command/pose beats, o_res gives drive beats; both are
// valid/ready. Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// (0 step_size, 1 arrive_tolerance, 2 heading_tolerance, 3 turn_rate,
// 4 forward_speed) by the user only while the block is idle; the block does not check.
// A move command, or a pose update while idle, completes in its accept cycle
// and produces no beat; i_cmd.ready stays high, so such beats go back to back.
// A pose update while moving runs the sequencer: one shared 25x25 multiplier
// forms tolerance^2, dx^2 and dy^2 in turn (S_SQT, S_SQX, S_SQY), then one
// compare (S_CMP). On arrival the stop beat goes out through S_PUSH. Otherwise
// the CORDIC unit runs CORDIC_STEPS rotations (14), one per cycle, then S_ERR
// forms the drive beat, which goes out through S_PUSH. i_cmd.ready is low during
// that run and rises when the result is loaded, so a new pose is taken only
// after the last one's result is loaded; the sequencer and CORDIC set the pace.
// The result sits in an output register; a stalled receiver holds it, and a
// new beat is accepted meanwhile, but the next result waits until it is taken.
// Synchronous active-low reset clears position, goal, motion flag, config to
// defaults and the output valid.
`default_nettype none
module grid_step_goto_controller_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [gsg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [gsg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    gsg_in_if.sink                                 i_cmd,
    gsg_out_if.source                              o_res
);

    localparam int POS_W  = gsg_pkg::POS_W;
    localparam int DIFF_W = gsg_pkg::DIFF_W;
    localparam int SUM_W  = gsg_pkg::SUM_W;
    localparam int ERR_W  = gsg_pkg::ERR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQT,
        S_SQX,
        S_SQY,
        S_CMP,
        S_CORD,
        S_ERR,
        S_PUSH
    } t_state;

    t_state                                r_state;
    logic signed [POS_W-1:0]               r_pos_x;
    logic signed [POS_W-1:0]               r_pos_y;
    logic signed [POS_W-1:0]               r_goal_x;
    logic signed [POS_W-1:0]               r_goal_y;
    logic                                  r_moving;
    logic signed [DIFF_W-1:0]              r_dx;
    logic signed [DIFF_W-1:0]              r_dy;
    logic signed [gsg_pkg::HEAD_W-1:0]     r_head;
    logic signed [gsg_pkg::PROD_W-1:0]     r_prod;
    logic [gsg_pkg::SQ_W-1:0]              r_acc;
    logic [gsg_pkg::TOL2_W-1:0]            r_tol2;
    logic signed [ERR_W-1:0]               r_err;
    logic                                  r_cord_start;
    logic [gsg_pkg::LIN_W-1:0]             r_res_lin;
    logic signed [gsg_pkg::RATE_W-1:0]     r_res_ang;
    logic                                  r_res_arr;
    logic                                  r_out_valid;
    logic [gsg_pkg::LIN_W-1:0]             r_out_lin;
    logic signed [gsg_pkg::RATE_W-1:0]     r_out_ang;
    logic                                  r_out_arr;

    gsg_pkg::t_cfg                         cfg;
    gsg_pkg::t_cordic_req                  cord_req;
    gsg_pkg::t_cordic_rsp                  cord_rsp;

    logic                                  in_acc;
    logic                                  push_out;
    logic                                  dir_ok;
    logic                                  dir_vert;
    logic                                  dir_neg;
    logic signed [SUM_W-1:0]               base_ext;
    logic signed [SUM_W-1:0]               step_ext;
    logic signed [SUM_W-1:0]               goal_sum;
    logic signed [POS_W-1:0]               goal_sat;
    logic signed [DIFF_W-1:0]              dx_in;
    logic signed [DIFF_W-1:0]              dy_in;
    logic signed [DIFF_W-1:0]              mul_a;
    logic signed [gsg_pkg::PROD_W-1:0]     mul_p;
    logic [gsg_pkg::D2_W-1:0]              d2;
    logic                                  near;
    logic signed [ERR_W-1:0]               err_w;
    logic [ERR_W-1:0]                      err_abs;
    logic signed [gsg_pkg::RATE_W-1:0]     turn_pos;

    gsg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign cord_req.start = r_cord_start;
    assign cord_req.dx    = r_dx;
    assign cord_req.dy    = r_dy;

    gsg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cord_req),
        .o_rsp   (cord_rsp)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign in_acc      = i_cmd.valid && i_cmd.ready;
    assign push_out    = (r_state == S_PUSH) && (!r_out_valid || o_res.ready);

    // goal one step away, saturated to the position range
    assign dir_ok   = (i_cmd.direction == gsg_pkg::DIR_UP)
                   || (i_cmd.direction == gsg_pkg::DIR_DOWN)
                   || (i_cmd.direction == gsg_pkg::DIR_RIGHT)
                   || (i_cmd.direction == gsg_pkg::DIR_LEFT);
    assign dir_vert = (i_cmd.direction == gsg_pkg::DIR_UP)
                   || (i_cmd.direction == gsg_pkg::DIR_DOWN);
    assign dir_neg  = (i_cmd.direction == gsg_pkg::DIR_DOWN)
                   || (i_cmd.direction == gsg_pkg::DIR_LEFT);
    assign base_ext = dir_vert ? SUM_W'(r_pos_y) : SUM_W'(r_pos_x);
    assign step_ext = $signed({{(SUM_W - gsg_pkg::STEP_W){1'b0}}, cfg.step_size});
    assign goal_sum = dir_neg ? (base_ext - step_ext) : (base_ext + step_ext);

    always_comb begin
        if (goal_sum > SUM_W'(gsg_pkg::POS_MAX)) begin
            goal_sat = gsg_pkg::POS_MAX;
        end else if (goal_sum < SUM_W'(gsg_pkg::POS_MIN)) begin
            goal_sat = gsg_pkg::POS_MIN;
        end else begin
            goal_sat = goal_sum[POS_W-1:0];
        end
    end

    assign dx_in = DIFF_W'(r_goal_x) - DIFF_W'(i_cmd.pose_x);
    assign dy_in = DIFF_W'(r_goal_y) - DIFF_W'(i_cmd.pose_y);

    // shared squarer
    always_comb begin
        case (r_state)
            S_SQT:   mul_a = $signed({{(DIFF_W - gsg_pkg::TOL_W){1'b0}},
                                      cfg.arrive_tolerance});
            S_SQX:   mul_a = r_dx;
            default: mul_a = r_dy;
        endcase
    end
    assign mul_p = mul_a * mul_a;

    assign d2   = {1'b0, r_acc} + {1'b0, r_prod[gsg_pkg::SQ_W-1:0]};
    assign near = d2 < gsg_pkg::D2_W'(r_tol2);

    // heading error wrapped once into [-pi, pi]
    always_comb begin
        if (r_err > gsg_pkg::ANG_PI) begin
            err_w = r_err - gsg_pkg::ANG_TWO_PI;
        end else if (r_err < -gsg_pkg::ANG_PI) begin
            err_w = r_err + gsg_pkg::ANG_TWO_PI;
        end else begin
            err_w = r_err;
        end
    end
    assign err_abs  = err_w[ERR_W-1] ? ERR_W'(-err_w) : ERR_W'(err_w);
    assign turn_pos = $signed({1'b0, cfg.turn_rate});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_goal_x     <= '0;
            r_goal_y     <= '0;
            r_moving     <= 1'b0;
            r_cord_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cord_start <= (r_state == S_CMP) && !near;
            if (push_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_cmd.command == gsg_pkg::CMD_MOVE) begin
                            if (!r_moving && dir_ok) begin
                                r_goal_x <= dir_vert ? r_pos_x : goal_sat;
                                r_goal_y <= dir_vert ? goal_sat : r_pos_y;
                                r_moving <= 1'b1;
                            end
                        end else begin
                            r_pos_x <= i_cmd.pose_x;
                            r_pos_y <= i_cmd.pose_y;
                            if (r_moving) begin
                                r_dx    <= dx_in;
                                r_dy    <= dy_in;
                                r_head  <= i_cmd.pose_heading;
                                r_state <= S_SQT;
                            end
                        end
                    end
                end
                S_SQT: begin
                    r_prod  <= mul_p;
                    r_state <= S_SQX;
                end
                S_SQX: begin
                    r_tol2  <= r_prod[gsg_pkg::TOL2_W-1:0];
                    r_prod  <= mul_p;
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_acc   <= r_prod[gsg_pkg::SQ_W-1:0];
                    r_prod  <= mul_p;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (near) begin
                        r_pos_x   <= r_goal_x;
                        r_pos_y   <= r_goal_y;
                        r_moving  <= 1'b0;
                        r_res_lin <= '0;
                        r_res_ang <= '0;
                        r_res_arr <= 1'b1;
                        r_state   <= S_PUSH;
                    end else begin
                        r_state   <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (cord_rsp.done) begin
                        r_err   <= ERR_W'(cord_rsp.angle) - ERR_W'(r_head);
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    if (err_abs > ERR_W'(cfg.heading_tolerance)) begin
                        r_res_lin <= '0;
                        r_res_ang <= (err_w > 0) ? turn_pos : -turn_pos;
                    end else begin
                        r_res_lin <= cfg.forward_speed;
                        r_res_ang <= '0;
                    end
                    r_res_arr <= 1'b0;
                    r_state   <= S_PUSH;
                end
                S_PUSH: begin
                    if (push_out) begin
                        r_out_lin   <= r_res_lin;
                        r_out_ang   <= r_res_ang;
                        r_out_arr   <= r_res_arr;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.linear_speed = r_out_lin;
    assign o_res.angular_rate = r_out_ang;
    assign o_res.arrived      = r_out_arr;

endmodule
`default_nettype wire

FILE: hdl/gsg_chk.sv
// Port-level checker for the grid step controller, bound to the top level
`default_nettype none
module gsg_chk (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_ready,
    input  wire logic                              in_command,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire logic [gsg_pkg::LIN_W-1:0]         out_lin,
    input  wire logic signed [gsg_pkg::RATE_W-1:0] out_ang,
    input  wire logic                              out_arr
);

    // a waiting result beat holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_lin)
                                   && $stable(out_ang) && $stable(out_arr))
        else $error("result beat changed while stalled");

    // a stop on arrival carries no motion
    a_arrive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_arr |-> (out_lin == '0) && (out_ang == '0))
        else $error("arrival beat with nonzero speed");

    // never drive and turn at once
    a_drive_or_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_lin == '0) || (out_ang == '0))
        else $error("forward speed and turn rate both nonzero");

    // move commands finish at once
    a_move_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && (in_command == gsg_pkg::CMD_MOVE) |=> in_ready)
        else $error("input not ready after a move command");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid && in_ready)
        else $error("reset did not clear the channels");

endmodule

bind grid_step_goto_controller_unit gsg_chk u_gsg_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (i_cmd.valid),
    .in_ready   (i_cmd.ready),
    .in_command (i_cmd.command),
    .out_valid  (o_res.valid),
    .out_ready  (o_res.ready),
    .out_lin    (o_res.linear_speed),
    .out_ang    (o_res.angular_rate),
    .out_arr    (o_res.arrived)
);
`default_nettype wire
